// ===== hdl/sral_pkg.sv =====
package sral_pkg;

  localparam int DIM       = 6;
  localparam int NUM_UPPER = DIM * (DIM + 1) / 2;
  localparam int IN_W      = 24;
  localparam int VAL_W     = 64;
  localparam int IDX_W     = 3;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [IN_W-1:0]  in_word_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // Saturating signed add: clamp to the rail that matches the operand sign.
  function automatic val_t sat_add(input val_t a, input val_t b);
    val_t s;
    s = a + b;
    if ((a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1])) begin
      s = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
    end
    return s;
  endfunction

endpackage

// ===== hdl/sral_if.sv =====
interface sral_in_if;
  import sral_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic signed [IN_W-1:0] vec_0;
  logic signed [IN_W-1:0] vec_1;
  logic signed [IN_W-1:0] vec_2;
  logic signed [IN_W-1:0] vec_3;
  logic signed [IN_W-1:0] vec_4;
  logic signed [IN_W-1:0] vec_5;
  logic signed [IN_W-1:0] alpha;
  logic [IDX_W-1:0]       entry_row;
  logic [IDX_W-1:0]       entry_col;
  logic signed [VAL_W-1:0] entry_value;

  modport source (
    output valid, op, vec_0, vec_1, vec_2, vec_3, vec_4, vec_5, alpha,
           entry_row, entry_col, entry_value,
    input  ready
  );
  modport sink (
    input  valid, op, vec_0, vec_1, vec_2, vec_3, vec_4, vec_5, alpha,
           entry_row, entry_col, entry_value,
    output ready
  );
endinterface

interface sral_out_if;
  import sral_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// ===== hdl/sral_cell.sv =====
module sral_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             shift,
  input  logic signed [sral_pkg::VAL_W-1:0] d,
  output logic signed [sral_pkg::VAL_W-1:0] q
);
  import sral_pkg::*;

  val_t val_r;

  // Hold one matrix entry; take the neighbor's entry on a ring step.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      val_r <= '0;
    end else if (shift) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// ===== hdl/sral_term.sv =====
module sral_term (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              issue,
  input  logic signed [sral_pkg::IN_W-1:0]  alpha,
  input  logic signed [sral_pkg::IN_W-1:0]  u_i,
  input  logic signed [sral_pkg::IN_W-1:0]  u_j,
  output logic                              term_valid,
  output logic signed [sral_pkg::VAL_W-1:0] term
);
  import sral_pkg::*;

  localparam int P_W  = 2 * IN_W;
  localparam int ML_W = 2 * IN_W + 1;

  logic                   v1_r, v2_r, v3_r;
  logic signed [P_W-1:0]  p_r;
  in_word_t               uj_r;
  logic signed [IN_W-1:0] hi;
  logic signed [IN_W:0]   lo;
  logic signed [P_W-1:0]  mh_r;
  logic signed [ML_W-1:0] ml_r;
  val_t                   term_r;

  // Split alpha*u_i into a floor-shifted high part and an unsigned low part.
  assign hi = $signed(p_r[P_W-1:IN_W]);
  assign lo = $signed({1'b0, p_r[IN_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= alpha * u_i;
    uj_r   <= u_j;
    mh_r   <= hi * uj_r;
    ml_r   <= lo * uj_r;
    term_r <= {{(VAL_W-P_W){mh_r[P_W-1]}}, mh_r}
            + {{(VAL_W-(ML_W-IN_W)){ml_r[ML_W-1]}}, ml_r[ML_W-1:IN_W]};
  end

  assign term_valid = v3_r;
  assign term       = term_r;

endmodule

// ===== hdl/symmetric_rank_one_accumulator_core.sv =====
// Work per item: clear zeroes all entries; add of one entry takes 21
// ring steps; rank update takes 21 issues into a 3-stage product pipeline
// feeding the ring, one ring step per term; read out takes 6 ring turns
// of 21 steps plus output stalls, each result item going into the output
// register at its ring step. One item is worked at a time.
// Reset (synchronous, rst_n low) zeroes all 21 entries and the control state.
module symmetric_rank_one_accumulator_core (
  input  logic        clk,
  input  logic        rst_n,
  sral_in_if.sink     in_ch,
  sral_out_if.source  out_ch
);
  import sral_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t state_r;

  // Ring of entry cells. The head cell always holds the packed entry
  // (hr_r, hc_r), upper triangle order; every step moves each entry one
  // cell toward the head and writes the head entry, updated, into the tail.
  val_t cell_q [NUM_UPPER];
  val_t ring_in;
  val_t addend;
  logic ring_adv;
  logic clr_all;
  logic [IDX_W-1:0] hr_r, hc_r;
  logic head_end;

  // Captured item.
  in_word_t         alpha_r;
  in_word_t         vi_r [DIM];
  in_word_t         vj_r [DIM];
  logic [IDX_W-1:0] tr_r, tc_r;
  val_t             addv_r;

  // Term issue for the rank update.
  logic             issue_r;
  logic [IDX_W-1:0] ic_r, ir_r;
  logic             term_valid;
  val_t             term;

  // Read out.
  logic [IDX_W-1:0] rd_row_r;
  logic             need;
  logic             emit;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  val_t             out_value_r;
  logic             out_last_r;

  logic             accept;
  logic [IDX_W-1:0] lo_idx, hi_idx;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign clr_all     = accept && (in_ch.op == OP_CLEAR);

  assign lo_idx = (in_ch.entry_row > in_ch.entry_col) ? in_ch.entry_col : in_ch.entry_row;
  assign hi_idx = (in_ch.entry_row > in_ch.entry_col) ? in_ch.entry_row : in_ch.entry_col;

  assign head_end = (hr_r == IDX_LAST) && (hc_r == IDX_LAST);

  // The head entry belongs to the current read row when it sits in that
  // row or, mirrored, in that column; within a row they pass in column order.
  assign need = (hr_r == rd_row_r) || (hc_r == rd_row_r);
  assign emit = (state_r == ST_READ) && need && (!out_valid_r || out_ch.ready);

  always_comb begin
    ring_adv = 1'b0;
    addend   = '0;
    case (state_r)
      ST_UPD: begin
        ring_adv = term_valid;
        addend   = term;
      end
      ST_ADD: begin
        ring_adv = 1'b1;
        if ((hr_r == tr_r) && (hc_r == tc_r)) begin
          addend = addv_r;
        end
      end
      ST_READ: begin
        ring_adv = !need || !out_valid_r || out_ch.ready;
      end
      default: begin
        ring_adv = 1'b0;
      end
    endcase
  end

  assign ring_in = sat_add(cell_q[0], addend);

  genvar n;
  generate
    for (n = 0; n < NUM_UPPER; n++) begin : g_cell
      val_t d;
      if (n == NUM_UPPER - 1) begin : g_tail
        assign d = ring_in;
      end else begin : g_body
        assign d = cell_q[n+1];
      end
      sral_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr_all),
        .shift (ring_adv),
        .d     (d),
        .q     (cell_q[n])
      );
    end
  endgenerate

  sral_term u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue_r),
    .alpha      (alpha_r),
    .u_i        (vi_r[0]),
    .u_j        (vj_r[0]),
    .term_valid (term_valid),
    .term       (term)
  );

  // Sequencer and ring position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hr_r     <= '0;
      hc_r     <= '0;
      rd_row_r <= '0;
    end else begin
      if (accept) begin
        case (in_ch.op)
          OP_UPDATE: state_r <= ST_UPD;
          OP_ADD: begin
            // Drop an add that points outside the matrix.
            if ((in_ch.entry_row <= IDX_LAST) && (in_ch.entry_col <= IDX_LAST)) begin
              state_r <= ST_ADD;
            end
          end
          OP_READ: begin
            state_r  <= ST_READ;
            rd_row_r <= '0;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
      if (ring_adv) begin
        if (head_end) begin
          hr_r <= '0;
          hc_r <= '0;
          if (state_r == ST_READ) begin
            rd_row_r <= rd_row_r + 1'b1;
            if (rd_row_r == IDX_LAST) begin
              state_r <= ST_IDLE;
            end
          end else begin
            state_r <= ST_IDLE;
          end
        end else if (hc_r == IDX_LAST) begin
          hr_r <= hr_r + 1'b1;
          hc_r <= hr_r + 1'b1;
        end else begin
          hc_r <= hc_r + 1'b1;
        end
      end
    end
  end

  // Issue one (i, j) product a cycle; vi_r heads with u_i, vj_r with u_j.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      ir_r    <= '0;
      ic_r    <= '0;
    end else if (accept && (in_ch.op == OP_UPDATE)) begin
      issue_r <= 1'b1;
      ir_r    <= '0;
      ic_r    <= '0;
    end else if (issue_r) begin
      if ((ir_r == IDX_LAST) && (ic_r == IDX_LAST)) begin
        issue_r <= 1'b0;
      end else if (ic_r == IDX_LAST) begin
        ir_r <= ir_r + 1'b1;
        ic_r <= ir_r + 1'b1;
      end else begin
        ic_r <= ic_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alpha_r <= in_ch.alpha;
      vi_r[0] <= in_ch.vec_0;
      vi_r[1] <= in_ch.vec_1;
      vi_r[2] <= in_ch.vec_2;
      vi_r[3] <= in_ch.vec_3;
      vi_r[4] <= in_ch.vec_4;
      vi_r[5] <= in_ch.vec_5;
      vj_r[0] <= in_ch.vec_0;
      vj_r[1] <= in_ch.vec_1;
      vj_r[2] <= in_ch.vec_2;
      vj_r[3] <= in_ch.vec_3;
      vj_r[4] <= in_ch.vec_4;
      vj_r[5] <= in_ch.vec_5;
      tr_r    <= lo_idx;
      tc_r    <= hi_idx;
      addv_r  <= in_ch.entry_value;
    end else if (issue_r) begin
      if (ic_r == IDX_LAST) begin
        // Next row: advance u_i and restart u_j on the diagonal.
        for (int k = 0; k < DIM - 1; k++) begin
          vi_r[k] <= vi_r[k+1];
          vj_r[k] <= vi_r[k+1];
        end
      end else begin
        for (int k = 0; k < DIM - 1; k++) begin
          vj_r[k] <= vj_r[k+1];
        end
      end
    end
  end

  // Output register: parts the ring from the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= rd_row_r;
      out_col_r   <= (hr_r == rd_row_r) ? hc_r : hr_r;
      out_value_r <= cell_q[0];
      out_last_r  <= (rd_row_r == IDX_LAST) && head_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule
